FILE: src/rvd_pkg.sv
// Shared types and constants for the RV32I subset decode stage.
// No dependencies; every other file of the block imports this package.
package rvd_pkg;

  localparam int XLEN       = 32;
  localparam int REG_ADDR_W = 5;
  localparam int NUM_REGS   = 1 << REG_ADDR_W;
  localparam int CFG_IDX_W  = 8;
  localparam int IMM_W      = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_SIZE = 8'd1;

  localparam logic [XLEN-1:0] STACK_LOW_RESET  = 32'd0;
  localparam logic [XLEN-1:0] STACK_SIZE_RESET = 32'd4096;

  // Register number of the stack pointer.
  localparam logic [REG_ADDR_W-1:0] SP_REG = 5'd2;

  // Major opcodes.
  localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_END    = 7'b1000000;
  localparam logic [6:0] OPC_NOP    = 7'b0000000;

  // funct7 and funct3 codes.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_SUB  = 7'b0100000;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // ALU operations.
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_AND = 2'd2;
  localparam logic [1:0] ALU_OR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OPC  = 2'd1;
  localparam logic [1:0] ST_BAD_FUNC = 2'd2;
  localparam logic [1:0] ST_SP_RANGE = 2'd3;

  typedef struct packed {
    logic [XLEN-1:0]       instruction;
    logic                  wb_enable;
    logic [REG_ADDR_W-1:0] wb_reg;
    logic [XLEN-1:0]       wb_data;
  } rvd_in_t;

  typedef struct packed {
    logic                    reg_write;
    logic                    alu_src;
    logic                    branch;
    logic                    mem_write;
    logic                    mem_read;
    logic                    halt;
    logic [1:0]              alu_op;
    logic [XLEN-1:0]         rs1_data;
    logic [XLEN-1:0]         rs2_value;
    logic [REG_ADDR_W-1:0]   rd;
    logic signed [IMM_W-1:0] imm;
    logic [1:0]              status;
  } rvd_out_t;

  // Decoded control word, before register data and the stack check are merged.
  typedef struct packed {
    logic                    reg_write;
    logic                    alu_src;
    logic                    branch;
    logic                    mem_write;
    logic                    mem_read;
    logic                    halt;
    logic [1:0]              alu_op;
    logic [REG_ADDR_W-1:0]   rd;
    logic signed [IMM_W-1:0] imm;
    logic [1:0]              status;
  } rvd_ctrl_t;

  // One register file write.
  typedef struct packed {
    logic                  en;
    logic [REG_ADDR_W-1:0] addr;
    logic [XLEN-1:0]       data;
  } rvd_wr_t;

endpackage

FILE: src/rvd_regfile.sv
// 32 x 32 register file with two registered read ports and one write port.
// Depends on rvd_pkg. Entries never written since reset read as zero.
module rvd_regfile
  import rvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  rvd_wr_t               wr,
  input  logic                  rd_en,
  input  logic [REG_ADDR_W-1:0] rd_addr1,
  input  logic [REG_ADDR_W-1:0] rd_addr2,
  output logic [XLEN-1:0]       rd_data1,
  output logic [XLEN-1:0]       rd_data2,
  output logic [XLEN-1:0]       sp_value
);

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] written;
  logic [XLEN-1:0]     mem_q1;
  logic [XLEN-1:0]     mem_q2;
  logic                hit_q1;
  logic                hit_q2;
  logic [XLEN-1:0]     sp_shadow;

  // Reads return the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q1 <= mem[rd_addr1];
      mem_q2 <= mem[rd_addr2];
    end
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      hit_q1    <= 1'b0;
      hit_q2    <= 1'b0;
      sp_shadow <= '0;
    end else begin
      if (rd_en) begin
        hit_q1 <= written[rd_addr1];
        hit_q2 <= written[rd_addr2];
      end
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
        if (wr.addr == SP_REG) begin
          sp_shadow <= wr.data;
        end
      end
    end
  end

  assign rd_data1 = hit_q1 ? mem_q1 : '0;
  assign rd_data2 = hit_q2 ? mem_q2 : '0;
  assign sp_value = sp_shadow;

endmodule

FILE: src/rvd_decoder.sv
// Instruction decoder: control signals, ALU operation, immediate and status.
// Depends on rvd_pkg; purely combinational.
module rvd_decoder
  import rvd_pkg::*;
(
  input  logic [XLEN-1:0] instruction,
  output rvd_ctrl_t       ctrl
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  rvd_ctrl_t  c;

  assign opc = instruction[6:0];
  assign f3  = instruction[14:12];
  assign f7  = instruction[31:25];

  always_comb begin
    c        = '0;
    c.rd     = instruction[11:7];
    c.status = ST_OK;
    c.alu_op = ALU_ADD;
    case (opc)
      OPC_RTYPE: begin
        c.reg_write = 1'b1;
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          c.alu_op = ALU_ADD;
        end else if (f7 == F7_SUB && f3 == F3_ADD) begin
          c.alu_op = ALU_SUB;
        end else if (f7 == F7_BASE && f3 == F3_AND) begin
          c.alu_op = ALU_AND;
        end else if (f7 == F7_BASE && f3 == F3_OR) begin
          c.alu_op = ALU_OR;
        end else begin
          c.status = ST_BAD_FUNC;
        end
      end
      OPC_IMM: begin
        c.reg_write = 1'b1;
        c.alu_src   = 1'b1;
        if (f3 == F3_ADD) begin
          c.alu_op = ALU_ADD;
        end else if (f3 == F3_AND) begin
          c.alu_op = ALU_AND;
        end else if (f3 == F3_OR) begin
          c.alu_op = ALU_OR;
        end else begin
          c.status = ST_BAD_FUNC;
        end
      end
      OPC_LOAD: begin
        c.reg_write = 1'b1;
        c.alu_src   = 1'b1;
        c.mem_read  = 1'b1;
      end
      OPC_STORE: begin
        c.alu_src   = 1'b1;
        c.mem_write = 1'b1;
      end
      OPC_BRANCH: begin
        c.branch = 1'b1;
        c.alu_op = ALU_SUB;
      end
      OPC_END: begin
        c.halt = 1'b1;
      end
      OPC_NOP: begin
      end
      default: begin
        c.status = ST_BAD_OPC;
      end
    endcase

    // A fault clears every control signal and the ALU operation.
    if (c.status != ST_OK) begin
      c.reg_write = 1'b0;
      c.alu_src   = 1'b0;
      c.branch    = 1'b0;
      c.mem_write = 1'b0;
      c.mem_read  = 1'b0;
      c.halt      = 1'b0;
      c.alu_op    = ALU_ADD;
    end

    // I layout for loads and immediates, S layout for everything else.
    if (opc == OPC_LOAD || opc == OPC_IMM) begin
      c.imm = {instruction[31:25], instruction[24:20]};
    end else begin
      c.imm = {instruction[31:25], instruction[11:7]};
    end
  end

  assign ctrl = c;

endmodule

FILE: src/rv32i_subset_decode_stage.sv
// Top level of the RV32I subset decode stage.
// Depends on rvd_pkg, rvd_regfile and rvd_decoder.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one beat per instruction,
//   together with the writeback request that the later stages hand back.
//   The writeback is written at the same edge as the source register reads and
//   forwarded, so a beat sees its own writeback. A writeback aimed at the stack
//   pointer (x2) is range checked against stack_low .. stack_low + stack_size
//   (computed without wrap); an out-of-range value is dropped and reported as
//   status 3 unless a decode fault is reported for the same beat.
//   Output channel (out_valid/out_ready/out_data) carries one decoded beat per
//   input beat, in order.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   stack_low (index 0) or stack_size (index 1); other indexes are ignored.
//   It is always ready and should only be used while the stage is empty.
// Timing:
//   From input beat to output beat, the register file read and the input item
//   are captured in the first register stage, and decode runs behind it into
//   the output register. One beat per cycle is sustained while out_ready stays
//   high; the single write and two read ports of the register file are all
//   used once per beat.
// Reset and stalls:
//   Synchronous reset empties both stages, clears the register file to zero
//   and restores the configuration reset values. When out_ready is low the
//   output register holds, the first stage still fills once, and in_ready
//   then drops until the output moves on.
module rv32i_subset_decode_stage
  import rvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rvd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rvd_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XLEN-1:0]      cfg_data
);

  // Configuration registers.
  logic [XLEN-1:0] stack_low;
  logic [XLEN-1:0] stack_size;

  // First stage: the accepted beat plus what was written for it.
  logic                  s1_valid;
  logic [XLEN-1:0]       s1_instr;
  logic                  s1_sp_bad;
  rvd_wr_t               s1_wr;

  logic                  s1_advance;
  logic                  in_accept;
  logic [XLEN-1:0]       sp_value;
  logic [XLEN-1:0]       wb_value;
  logic [XLEN:0]         stack_top;
  logic                  sp_bad;
  rvd_wr_t               wr;
  logic [XLEN-1:0]       rf_data1;
  logic [XLEN-1:0]       rf_data2;
  logic [REG_ADDR_W-1:0] s1_rs1;
  logic [REG_ADDR_W-1:0] s1_rs2;
  rvd_ctrl_t             ctrl;
  rvd_out_t              result;
  rvd_out_t              out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_low  <= STACK_LOW_RESET;
      stack_size <= STACK_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STACK_LOW:  stack_low  <= cfg_data;
        CFG_STACK_SIZE: stack_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the first stage moves whenever the output register is free
  // or being emptied this cycle.
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  // Stack pointer check on the value that would land in wb_reg. Without a
  // writeback the current x2 is checked, and a clean result leaves it as is.
  assign wb_value  = in_data.wb_enable ? in_data.wb_data : sp_value;
  assign stack_top = {1'b0, stack_low} + {1'b0, stack_size};
  assign sp_bad    = (in_data.wb_reg == SP_REG) &&
                     (({1'b0, wb_value} > stack_top) || (wb_value < stack_low));

  assign wr.en   = in_accept && in_data.wb_enable && !sp_bad;
  assign wr.addr = in_data.wb_reg;
  assign wr.data = in_data.wb_data;

  rvd_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (in_accept),
    .rd_addr1 (in_data.instruction[19:15]),
    .rd_addr2 (in_data.instruction[24:20]),
    .rd_data1 (rf_data1),
    .rd_data2 (rf_data2),
    .sp_value (sp_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_instr  <= in_data.instruction;
      s1_sp_bad <= sp_bad;
      s1_wr     <= wr;
    end
  end

  rvd_decoder u_decoder (
    .instruction (s1_instr),
    .ctrl        (ctrl)
  );

  // The register file read happened at the same edge as the write, so the
  // beat's own writeback is forwarded here.
  assign s1_rs1 = s1_instr[19:15];
  assign s1_rs2 = s1_instr[24:20];

  always_comb begin
    result           = '0;
    result.reg_write = ctrl.reg_write;
    result.alu_src   = ctrl.alu_src;
    result.branch    = ctrl.branch;
    result.mem_write = ctrl.mem_write;
    result.mem_read  = ctrl.mem_read;
    result.halt      = ctrl.halt;
    result.alu_op    = ctrl.alu_op;
    result.rd        = ctrl.rd;
    result.imm       = ctrl.imm;
    result.rs1_data  = (s1_wr.en && s1_wr.addr == s1_rs1) ? s1_wr.data : rf_data1;
    result.rs2_value = (s1_wr.en && s1_wr.addr == s1_rs2) ? s1_wr.data : rf_data2;
    // A decode fault outranks the stack pointer fault.
    if (ctrl.status != ST_OK) begin
      result.status = ctrl.status;
    end else if (s1_sp_bad) begin
      result.status = ST_SP_RANGE;
    end else begin
      result.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_q <= result;
    end
  end

  assign out_data = out_q;

endmodule

FILE: test/rvd_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the RV32I subset decode stage: watches the three channels, keeps its
// own register file and stack window, predicts each output beat and compares it.
// Depends on rvd_pkg for the beat types, opcodes and status codes.
module rvd_decode_checker
  import rvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  rvd_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  rvd_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XLEN-1:0]      cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  logic [XLEN-1:0] gpr [NUM_REGS];
  logic [XLEN-1:0] win_low;
  logic [XLEN-1:0] win_size;
  rvd_out_t        decoded_q[$];
  rvd_out_t        want;
  int              results_seen;

  // Decodes one input beat against the local register file, applying the
  // writeback (with the stack pointer window check) before the reads.
  function automatic rvd_out_t decode_beat(input rvd_in_t beat);
    logic [6:0]      opc;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] wb_val;
    logic [XLEN:0]   win_top;
    logic            sp_fault;
    rvd_out_t        res;
    opc = beat.instruction[6:0];
    f3  = beat.instruction[14:12];
    f7  = beat.instruction[31:25];
    res = '0;
    case (opc)
      OPC_RTYPE: begin
        res.reg_write = 1'b1;
        if (f7 == F7_BASE && f3 == F3_ADD) res.alu_op = ALU_ADD;
        else if (f7 == F7_SUB && f3 == F3_ADD) res.alu_op = ALU_SUB;
        else if (f7 == F7_BASE && f3 == F3_AND) res.alu_op = ALU_AND;
        else if (f7 == F7_BASE && f3 == F3_OR) res.alu_op = ALU_OR;
        else res.status = ST_BAD_FUNC;
      end
      OPC_IMM: begin
        res.reg_write = 1'b1;
        res.alu_src   = 1'b1;
        if (f3 == F3_ADD) res.alu_op = ALU_ADD;
        else if (f3 == F3_AND) res.alu_op = ALU_AND;
        else if (f3 == F3_OR) res.alu_op = ALU_OR;
        else res.status = ST_BAD_FUNC;
      end
      OPC_LOAD: begin
        res.reg_write = 1'b1;
        res.alu_src   = 1'b1;
        res.mem_read  = 1'b1;
      end
      OPC_STORE: begin
        res.alu_src   = 1'b1;
        res.mem_write = 1'b1;
      end
      OPC_BRANCH: begin
        res.branch = 1'b1;
        res.alu_op = ALU_SUB;
      end
      OPC_END: res.halt = 1'b1;
      OPC_NOP: ;
      default: res.status = ST_BAD_OPC;
    endcase
    // A decode fault clears every control signal.
    if (res.status != ST_OK) begin
      res.reg_write = 1'b0;
      res.alu_src   = 1'b0;
      res.branch    = 1'b0;
      res.mem_write = 1'b0;
      res.mem_read  = 1'b0;
      res.halt      = 1'b0;
      res.alu_op    = ALU_ADD;
    end
    wb_val   = beat.wb_enable ? beat.wb_data : gpr[beat.wb_reg];
    win_top  = {1'b0, win_low} + {1'b0, win_size};
    sp_fault = (beat.wb_reg == SP_REG) &&
               (({1'b0, wb_val} > win_top) || (wb_val < win_low));
    if (!sp_fault) gpr[beat.wb_reg] = wb_val;
    if (sp_fault && res.status == ST_OK) res.status = ST_SP_RANGE;
    res.rs1_data  = gpr[beat.instruction[19:15]];
    res.rs2_value = gpr[beat.instruction[24:20]];
    res.rd        = beat.instruction[11:7];
    res.imm       = {beat.instruction[31:25],
                     (opc == OPC_LOAD || opc == OPC_IMM) ? beat.instruction[24:20]
                                                         : beat.instruction[11:7]};
    return res;
  endfunction

  task automatic note(input string what, input logic [XLEN-1:0] exp_v,
                      input logic [XLEN-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] result %0d, %s: expected %h, got %h",
               $time, results_seen, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      win_low  = STACK_LOW_RESET;
      win_size = STACK_SIZE_RESET;
      decoded_q.delete();
      mismatches   = 0;
      results_seen = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STACK_LOW:  win_low  = cfg_data;
          CFG_STACK_SIZE: win_size = cfg_data;
          default: ;
        endcase
      end
      // Outputs are compared before this edge's input is predicted, so a beat
      // can never be matched against its own same-cycle input.
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          note("unexpected output beat", '0, '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.reg_write !== want.reg_write)
            note("reg_write", want.reg_write, out_data.reg_write);
          if (out_data.alu_src !== want.alu_src)
            note("alu_src", want.alu_src, out_data.alu_src);
          if (out_data.branch !== want.branch)
            note("branch", want.branch, out_data.branch);
          if (out_data.mem_write !== want.mem_write)
            note("mem_write", want.mem_write, out_data.mem_write);
          if (out_data.mem_read !== want.mem_read)
            note("mem_read", want.mem_read, out_data.mem_read);
          if (out_data.halt !== want.halt)
            note("halt", want.halt, out_data.halt);
          if (out_data.alu_op !== want.alu_op)
            note("alu_op", want.alu_op, out_data.alu_op);
          if (out_data.rs1_data !== want.rs1_data)
            note("rs1_data", want.rs1_data, out_data.rs1_data);
          if (out_data.rs2_value !== want.rs2_value)
            note("rs2_value", want.rs2_value, out_data.rs2_value);
          if (out_data.rd !== want.rd)
            note("rd", want.rd, out_data.rd);
          if (out_data.imm !== want.imm)
            note("imm", want.imm, out_data.imm);
          if (out_data.status !== want.status)
            note("status", want.status, out_data.status);
        end
        results_seen++;
      end
      if (in_valid && in_ready) decoded_q.push_back(decode_beat(in_data));
      outstanding <= decoded_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the decode stage testbench: drives instruction, output and configuration
// traffic and gives the verdict. Depends on rvd_pkg, rvd_decode_checker and the block.
module tb_top;
  import rvd_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rvd_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rvd_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STACK_LOW;
  logic [XLEN-1:0]      cfg_data = '0;

  int mismatches;
  int outstanding;

  // When steady is high neither side idles; one whole window setting runs so.
  logic            steady = 1'b0;
  logic [XLEN-1:0] sp_low_now  = STACK_LOW_RESET;
  logic [XLEN-1:0] sp_size_now = STACK_SIZE_RESET;
  int              beats_sent = 0;
  int              windows = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rv32i_subset_decode_stage uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rvd_decode_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver stalls with a probability of about 30 percent, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  function automatic logic [31:0] build(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic opc_known(input logic [6:0] opc);
    case (opc)
      OPC_RTYPE, OPC_IMM, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_END, OPC_NOP:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  // Picks an instruction word: mostly well-formed opcodes with random fields,
  // plus bad functs, unknown opcodes and fully random words.
  function automatic logic [31:0] random_word();
    int         kind;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [6:0] opc;
    kind = $urandom_range(99);
    f7   = 7'($urandom);
    f3   = 3'($urandom);
    opc  = OPC_NOP;
    if (kind < 12) begin
      opc = OPC_RTYPE;
      case ($urandom_range(3))
        0: begin f7 = F7_BASE; f3 = F3_ADD; end
        1: begin f7 = F7_SUB;  f3 = F3_ADD; end
        2: begin f7 = F7_BASE; f3 = F3_AND; end
        default: begin f7 = F7_BASE; f3 = F3_OR; end
      endcase
    end else if (kind < 15) begin
      // Either a funct7 that is neither base nor sub, or a funct3 outside the set.
      opc = OPC_RTYPE;
      if ($urandom_range(1) == 0) begin
        f7 = f7 | 7'h01;
        f3 = F3_ADD;
      end else begin
        f7 = F7_BASE;
        f3 = 3'($urandom_range(5, 1));
      end
    end else if (kind < 27) begin
      opc = OPC_IMM;
      case ($urandom_range(2))
        0: f3 = F3_ADD;
        1: f3 = F3_AND;
        default: f3 = F3_OR;
      endcase
    end else if (kind < 30) begin
      opc = OPC_IMM;
      f3  = 3'($urandom_range(5, 1));
    end else if (kind < 40) opc = OPC_LOAD;
    else if (kind < 50) opc = OPC_STORE;
    else if (kind < 60) opc = OPC_BRANCH;
    else if (kind < 65) opc = OPC_END;
    else if (kind < 70) opc = OPC_NOP;
    else if (kind < 80) begin
      do opc = 7'($urandom); while (opc_known(opc));
    end else begin
      return $urandom;
    end
    return build(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), opc);
  endfunction

  // Adds a writeback; a quarter of them aim at the stack pointer, with data
  // clustered on the edges of the current stack window.
  function automatic rvd_in_t make_beat(input logic [31:0] word);
    rvd_in_t         beat;
    longint unsigned span;
    longint unsigned offset;
    beat.instruction = word;
    beat.wb_enable   = ($urandom_range(99) < 75);
    beat.wb_reg      = ($urandom_range(99) < 25) ? SP_REG : 5'($urandom);
    beat.wb_data     = $urandom;
    if (beat.wb_reg == SP_REG) begin
      span   = 64'(sp_size_now) + 64'd1;
      offset = {$urandom, $urandom} % span;
      case ($urandom_range(5))
        0: beat.wb_data = sp_low_now - 32'd1;
        1: beat.wb_data = sp_low_now;
        2: beat.wb_data = sp_low_now + offset[31:0];
        3: beat.wb_data = sp_low_now + sp_size_now;
        4: beat.wb_data = sp_low_now + sp_size_now + 32'd1;
        default: ;
      endcase
    end
    return beat;
  endfunction

  // Offers one beat, after an optional idle gap, and returns at the edge that
  // accepts it. The caller either offers the next beat or lowers valid then.
  task automatic push_beat(input rvd_in_t beat);
    int gap;
    gap = (!steady && $urandom_range(99) < 30) ? $urandom_range(2, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drive(input logic [31:0] word, input logic wen,
                       input logic [4:0] wreg, input logic [31:0] wdata);
    rvd_in_t beat;
    beat.instruction = word;
    beat.wb_enable   = wen;
    beat.wb_reg      = wreg;
    beat.wb_data     = wdata;
    push_beat(beat);
  endtask

  // Drains the stage, then writes both window registers back to back with
  // valid held high across the two beats.
  task automatic set_window(input logic [31:0] lo, input logic [31:0] sz);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STACK_LOW;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_STACK_SIZE;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sp_low_now  = lo;
    sp_size_now = sz;
    windows++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset window (0 .. 4096).
    // Register 0 is writable and the same-beat writeback is visible to the read.
    drive(build(7'h00, 5'd0, 5'd0, 3'd0, 5'd0, OPC_NOP), 1'b1, 5'd0, 32'hFFFF_FFFF);
    drive(build(F7_BASE, 5'd0, 5'd31, F3_ADD, 5'd31, OPC_RTYPE), 1'b1, 5'd31, 32'h8000_0001);
    drive(build(F7_SUB, 5'd31, 5'd1, F3_ADD, 5'd1, OPC_RTYPE), 1'b1, 5'd1, 32'h1234_5678);
    drive(build(F7_BASE, 5'd1, 5'd31, F3_AND, 5'd3, OPC_RTYPE), 1'b0, 5'd3, 32'h0);
    drive(build(F7_BASE, 5'd1, 5'd0, F3_OR, 5'd4, OPC_RTYPE), 1'b1, 5'd4, 32'h5555_AAAA);
    // Unknown funct in both of its forms.
    drive(build(7'h7F, 5'd4, 5'd1, F3_ADD, 5'd5, OPC_RTYPE), 1'b1, 5'd5, 32'hDEAD_BEEF);
    drive(build(F7_BASE, 5'd5, 5'd4, 3'd1, 5'd6, OPC_RTYPE), 1'b1, 5'd6, 32'h0000_0001);
    // Immediate forms; funct7 must not matter.
    drive(build(7'h7F, 5'd31, 5'd6, F3_ADD, 5'd7, OPC_IMM), 1'b0, 5'd7, 32'hFFFF_FFFF);
    drive(build(7'h15, 5'd10, 5'd5, F3_AND, 5'd8, OPC_IMM), 1'b1, 5'd8, 32'h0F0F_0F0F);
    drive(build(7'h2A, 5'd21, 5'd8, F3_OR, 5'd9, OPC_IMM), 1'b1, 5'd9, 32'hF0F0_F0F0);
    drive(build(7'h00, 5'd3, 5'd9, 3'd2, 5'd10, OPC_IMM), 1'b1, 5'd10, 32'h7FFF_FFFF);
    // Immediate extremes: most negative as a load, most positive as a store.
    drive(build(7'h40, 5'd0, 5'd10, 3'd2, 5'd11, OPC_LOAD), 1'b1, 5'd11, 32'h0000_0100);
    drive(build(7'h3F, 5'd11, 5'd10, 3'd2, 5'd31, OPC_STORE), 1'b0, 5'd12, 32'h0);
    drive(build(7'h55, 5'd9, 5'd8, 3'd0, 5'd12, OPC_BRANCH), 1'b1, 5'd13, 32'hA5A5_A5A5);
    drive({25'h1FF_FFFF, OPC_END}, 1'b1, 5'd14, 32'h0000_FFFF);
    drive(build(7'h00, 5'd14, 5'd13, 3'd0, 5'd15, 7'h01), 1'b1, 5'd15, 32'h1);
    // Stack pointer window: top edge legal, one past it dropped, bottom edge legal.
    drive(32'hFFFF_FFFF, 1'b1, SP_REG, 32'd4096);
    drive(build(7'h00, 5'd2, 5'd2, 3'd0, 5'd0, OPC_NOP), 1'b1, SP_REG, 32'd4097);
    drive(build(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd16, OPC_RTYPE), 1'b1, SP_REG, 32'd0);
    // The current content is checked even without a write.
    drive(build(7'h00, 5'd2, 5'd2, 3'd0, 5'd0, OPC_NOP), 1'b0, SP_REG, 32'hFFFF_FFFF);
    // Decode fault and stack fault together: status shows the decode fault
    // while the write is still dropped, as the next read of x2 shows.
    drive(build(7'h00, 5'd2, 5'd2, 3'd0, 5'd17, 7'h7F), 1'b1, SP_REG, 32'hFFFF_FFFF);
    drive(build(7'h00, 5'd2, 5'd2, 3'd0, 5'd0, OPC_NOP), 1'b0, 5'd5, 32'h0);

    // Random traffic under several windows, extremes included. The fourth
    // setting runs with no idling on either side.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_window(32'h1000_0000, 32'h0000_0100);
        1: set_window(32'h0000_0000, 32'h0000_0000);
        2: set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_window(32'h0000_0000, 32'hFFFF_FFFF);
        4: set_window($urandom, $urandom_range(65535));
        default: set_window(32'h8000_0000, 32'h7FFF_FFFF);
      endcase
      steady <= (p == 3);
      repeat (240) push_beat(make_beat(random_word()));
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // Then keep clocking so that any stray output beat is still caught.
    repeat (4) @(posedge clk);
    $display("Drove %0d instruction beats under %0d stack window settings, all opcodes,",
             beats_sent, windows);
    $display("bad functs and stack faults, with random stalls on both channels.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("rv32i_subset_decode_stage test passed");
    end else begin
      $display("rv32i_subset_decode_stage test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #3000000;
    $display("rv32i_subset_decode_stage test failed");
    $finish;
  end

endmodule

FILE: sim.f
src/rvd_pkg.sv
src/rvd_regfile.sv
src/rvd_decoder.sv
src/rv32i_subset_decode_stage.sv
test/rvd_decode_checker.sv
test/tb_top.sv
